### design/vscd_pkg.sv
package vscd_pkg;

    localparam int GRID_WIDTH_DEF = 64;
    localparam int GRID_HEIGHT_DEF = 36;
    localparam int RECENT_LEN_DEF = 5;
    localparam int DIM_BITS_DEF = 13;

    localparam logic [15:0] CUT_THRESHOLD_RST = 16'd6912;
    localparam logic [15:0] MIN_SCENE_LENGTH_RST = 16'd15;
    localparam logic [15:0] ADAPTIVE_GAIN_RST = 16'd0;
    localparam logic [13:0] SOURCE_WIDTH_RST = 14'd1920;
    localparam logic [13:0] SOURCE_HEIGHT_RST = 14'd1080;

    localparam logic [15:0] U16_MAX = 16'hFFFF;

    // Exact division by three for values below 2^18.
    localparam int DIV3_SHIFT = 19;
    localparam logic [17:0] DIV3_MULT = 18'd174763;

    typedef enum logic [2:0] {
        REG_CUT_THRESHOLD    = 3'd0,
        REG_MIN_SCENE_LENGTH = 3'd1,
        REG_ADAPTIVE_GAIN    = 3'd2,
        REG_SOURCE_WIDTH     = 3'd3,
        REG_SOURCE_HEIGHT    = 3'd4
    } t_reg_idx;

endpackage

### design/video_scene_cut_detector.sv
// A source pixel that maps to no grid point passes through the column and row scans to the done state before ready.
// A sampled pixel adds an HSV conversion, dividing hue and saturation in parallel unless it is grey,
// and per grid point a read, compare and write-back of the previous-frame memory.
// A frame end adds up to two passes of the shared divider and a multiply step,
// and the result word is registered on the output. Reset is synchronous and active low;
// a clearing pass then marks all 2304 memory entries unwritten, one a cycle, before input.
module video_scene_cut_detector #(
    parameter int GRID_WIDTH  = vscd_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = vscd_pkg::GRID_HEIGHT_DEF,
    parameter int RECENT_LEN  = vscd_pkg::RECENT_LEN_DEF,
    parameter int DIM_BITS    = vscd_pkg::DIM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [47:0] i_frame_time,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_boundary,
    output logic [15:0] o_cut_score,
    output logic [15:0] o_frame_delta,
    output logic [47:0] o_boundary_time,
    output logic        o_first_frame
);

    import vscd_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int GXW   = $clog2(GRID_WIDTH + 1);
    localparam int GYW   = $clog2(GRID_HEIGHT + 1);
    localparam int DW1   = DIM_BITS + 1;
    localparam int PXW   = GXW + DW1;
    localparam int PYW   = GYW + DW1;
    localparam int CMPW  = $clog2(CELLS + 1);
    localparam int SUMW  = 16 + CMPW;
    localparam int DIV_W = (SUMW + 1 > 27) ? SUMW + 1 : 27;
    localparam int CNTW  = $clog2(RECENT_LEN + 1);
    localparam int RSW   = 16 + CNTW;
    localparam int LHSW  = 24 + CNTW;
    localparam int RHSW  = 32 + CNTW;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_COL, S_ROW, S_HSV, S_HSV_WAIT, S_RD, S_CMP, S_ACC, S_DONE,
        S_FDIV, S_FDIV_WAIT, S_SDIV, S_SDIV_WAIT, S_FMUL, S_FOUT
    } t_state;

    t_state r_state;

    logic [15:0] r_cut_threshold, r_min_scene_length, r_adaptive_gain;
    logic [13:0] r_source_width, r_source_height;

    logic [7:0]  r_red, r_green, r_blue;
    logic [47:0] r_time;
    logic        r_frame_end;

    logic [DIM_BITS-1:0] r_col;
    logic [DW1-1:0]      r_row;
    logic [GXW-1:0]      r_grid_col, r_gx, r_cx, r_ncols;
    logic [GYW-1:0]      r_grid_row, r_gy, r_nrows;

    logic        r_hsv_ok;
    logic [15:0] r_hue, r_sat, r_val;
    logic [17:0] r_s;
    logic        r_cmp_ok;
    logic [AW-1:0] r_clr_addr;

    logic [SUMW-1:0]  r_sum;
    logic [CMPW-1:0]  r_compared;
    logic             r_have_prev;
    logic [47:0]      r_prev_time;
    logic [15:0]      r_fsc;
    logic [15:0]      r_recent [RECENT_LEN];
    logic [CNTW-1:0]  r_recent_count;
    logic [RSW-1:0]   r_recent_sum;
    logic [15:0]      r_delta, r_score;
    logic [LHSW-1:0]  r_lhs;
    logic [RHSW-1:0]  r_rhs;

    logic        r_ovalid, r_obnd, r_ofirst;
    logic [15:0] r_oscore, r_odelta;
    logic [47:0] r_otime;

    logic [31:0]    sw32, sh32, lim32;
    logic [DW1-1:0] w_eff, h_eff;
    logic [15:0]    thr_eff, minlen_eff;
    logic           col_hit, row_hit, row_in;
    logic [AW-1:0]  addr;
    logic           cfg_wr;

    logic [7:0]       mx, mn, d;
    logic [10:0]      n;
    logic [DIV_W-1:0] hue_num, hue_den, sat_num, sat_den;

    logic             div_a_start, div_b_start, div_a_done, div_b_done;
    logic [DIV_W-1:0] div_a_num, div_a_den, div_a_quot, div_b_quot;

    logic        ram_re, ram_we;
    logic [AW-1:0] ram_waddr;
    logic [48:0] ram_wdata;
    logic [48:0] ram_rdata;
    logic [15:0] st_hue, st_sat, st_val;
    logic [16:0] hw;
    logic [24:0] hprod;
    logic [15:0] hd, sd, vd;
    logic [17:0] s_sum;
    logic [35:0] p3;
    logic [15:0] q3;

    logic             adapt, bnd;
    logic [15:0]      fsc_base, n_fsc;
    logic [CNTW-1:0]  cnt_base, n_recent_count;
    logic [RSW-1:0]   sum_base, n_recent_sum;
    logic [GXW-1:0]   cx_next;

    assign sw32  = 32'(r_source_width);
    assign sh32  = 32'(r_source_height);
    assign lim32 = 32'd1 << DIM_BITS;

    always_comb begin
        if (sw32 == 32'd0) begin
            w_eff = DW1'(1);
        end else if (sw32 > lim32) begin
            w_eff = DW1'(lim32);
        end else begin
            w_eff = DW1'(sw32);
        end
        if (sh32 == 32'd0) begin
            h_eff = DW1'(1);
        end else if (sh32 > lim32) begin
            h_eff = DW1'(lim32);
        end else begin
            h_eff = DW1'(sh32);
        end
    end

    assign thr_eff    = (r_cut_threshold == 16'd0) ? 16'd1 : r_cut_threshold;
    assign minlen_eff = (r_min_scene_length == 16'd0) ? 16'd1 : r_min_scene_length;

    // A grid point belongs to the current pixel while its scaled position stays below the
    // start of the next source pixel.
    assign col_hit = (r_gx < GXW'(GRID_WIDTH)) &&
                     ((PXW'(r_gx) * PXW'(w_eff)) <
                      ((PXW'(r_col) + PXW'(1)) * PXW'(GRID_WIDTH)));
    assign row_in  = r_row < h_eff;
    assign row_hit = (r_gy < GYW'(GRID_HEIGHT)) &&
                     ((PYW'(r_gy) * PYW'(h_eff)) <
                      ((PYW'(r_row) + PYW'(1)) * PYW'(GRID_HEIGHT)));
    assign addr    = AW'(r_gy) * AW'(GRID_WIDTH) + AW'(r_cx);
    assign cx_next = r_cx + GXW'(1);

    // RGB to HSV operands.
    always_comb begin
        mx = r_red;
        mn = r_red;
        if (r_green > mx) mx = r_green;
        if (r_blue > mx) mx = r_blue;
        if (r_green < mn) mn = r_green;
        if (r_blue < mn) mn = r_blue;
        d = mx - mn;
        if (d == 8'd0) begin
            n = 11'd0;
        end else if (mx == r_red) begin
            n = 11'(r_green) - 11'(r_blue) + ((r_green < r_blue) ? 11'(d) * 11'd6 : 11'd0);
        end else if (mx == r_green) begin
            n = 11'(r_blue) - 11'(r_red) + 11'(d) * 11'd2;
        end else begin
            n = 11'(r_red) - 11'(r_green) + 11'(d) * 11'd4;
        end
        hue_num = (DIV_W'(n) << 16) + DIV_W'(d) * DIV_W'(3);
        hue_den = DIV_W'(d) * DIV_W'(6);
        sat_num = DIV_W'(d) * DIV_W'(65280) + DIV_W'(mx >> 1);
        sat_den = DIV_W'(mx);
    end

    always_comb begin
        div_a_start = 1'b0;
        div_a_num   = hue_num;
        div_a_den   = hue_den;
        unique case (r_state)
            S_HSV: begin
                div_a_start = d != 8'd0;
            end
            S_FDIV: begin
                div_a_start = r_have_prev && (r_compared != '0);
                div_a_num   = DIV_W'(r_sum) + DIV_W'(r_compared >> 1);
                div_a_den   = DIV_W'(r_compared);
            end
            S_SDIV: begin
                div_a_start = 1'b1;
                div_a_num   = DIV_W'({r_delta, 8'd0}) + DIV_W'(thr_eff >> 1);
                div_a_den   = DIV_W'(thr_eff);
            end
            default: begin
            end
        endcase
    end

    assign div_b_start = (r_state == S_HSV) && (d != 8'd0);

    vscd_div #(.W(DIV_W)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_a_start),
        .i_num   (div_a_num),
        .i_den   (div_a_den),
        .o_done  (div_a_done),
        .o_quot  (div_a_quot)
    );

    vscd_div #(.W(DIV_W)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_b_start),
        .i_num   (sat_num),
        .i_den   (sat_den),
        .o_done  (div_b_done),
        .o_quot  (div_b_quot)
    );

    // The top bit of a memory word marks an entry that holds a sample.
    assign ram_re    = r_state == S_RD;
    assign ram_we    = (r_state == S_CMP) || (r_state == S_CLR);
    assign ram_waddr = (r_state == S_CLR) ? r_clr_addr : addr;
    assign ram_wdata = (r_state == S_CLR) ? 49'd0 : {1'b1, r_hue, r_sat, r_val};

    vscd_ram #(.WIDTH(49), .DEPTH(CELLS)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    // Distance of the new sample to the stored one, hue wrapped on the circle.
    always_comb begin
        st_hue = ram_rdata[47:32];
        st_sat = ram_rdata[31:16];
        st_val = ram_rdata[15:0];
        hw = (r_hue >= st_hue) ? 17'(r_hue - st_hue) : 17'(st_hue - r_hue);
        if (hw > 17'd32768) begin
            hw = 17'd65536 - hw;
        end
        hprod = (25'(hw) << 8) - 25'(hw) + 25'd128;
        hd    = hprod[23:8];
        sd    = (r_sat >= st_sat) ? r_sat - st_sat : st_sat - r_sat;
        vd    = (r_val >= st_val) ? r_val - st_val : st_val - r_val;
        s_sum = 18'(hd) + 18'(sd) + 18'(vd) + 18'd1;
    end

    assign p3 = 36'(r_s) * 36'(DIV3_MULT);
    assign q3 = p3[DIV3_SHIFT +: 16];

    // Frame decision.
    always_comb begin
        adapt = (r_adaptive_gain == 16'd0) || (r_recent_count == '0) || (r_lhs >= r_rhs);
        bnd   = r_have_prev && (r_compared != '0) && (r_delta >= thr_eff) && adapt &&
                (r_fsc >= minlen_eff) && (r_time >= r_prev_time);
        fsc_base = bnd ? 16'd0 : r_fsc;
        n_fsc    = (fsc_base == U16_MAX) ? fsc_base : fsc_base + 16'd1;
        cnt_base = bnd ? '0 : r_recent_count;
        sum_base = bnd ? '0 : r_recent_sum;
        if (cnt_base < CNTW'(RECENT_LEN)) begin
            n_recent_count = cnt_base + CNTW'(1);
            n_recent_sum   = sum_base + RSW'(r_delta);
        end else begin
            n_recent_count = cnt_base;
            n_recent_sum   = sum_base - RSW'(r_recent[0]) + RSW'(r_delta);
        end
    end

    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_CUT_THRESHOLD:    prdata = 32'(r_cut_threshold);
            REG_MIN_SCENE_LENGTH: prdata = 32'(r_min_scene_length);
            REG_ADAPTIVE_GAIN:    prdata = 32'(r_adaptive_gain);
            REG_SOURCE_WIDTH:     prdata = 32'(r_source_width);
            REG_SOURCE_HEIGHT:    prdata = 32'(r_source_height);
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_CLR;
            r_clr_addr         <= '0;
            r_cut_threshold    <= CUT_THRESHOLD_RST;
            r_min_scene_length <= MIN_SCENE_LENGTH_RST;
            r_adaptive_gain    <= ADAPTIVE_GAIN_RST;
            r_source_width     <= SOURCE_WIDTH_RST;
            r_source_height    <= SOURCE_HEIGHT_RST;
            r_col              <= '0;
            r_row              <= '0;
            r_grid_col         <= '0;
            r_grid_row         <= '0;
            r_sum              <= '0;
            r_compared         <= '0;
            r_have_prev        <= 1'b0;
            r_prev_time        <= '0;
            r_fsc              <= MIN_SCENE_LENGTH_RST;
            r_recent_count     <= '0;
            r_recent_sum       <= '0;
            r_ovalid           <= 1'b0;
            for (int i = 0; i < RECENT_LEN; i++) begin
                r_recent[i] <= '0;
            end
        end else begin
            if (r_ovalid && i_ready && (r_state != S_FOUT)) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[4:2]))
                    REG_CUT_THRESHOLD: r_cut_threshold <= pwdata[15:0];
                    REG_MIN_SCENE_LENGTH: begin
                        r_min_scene_length <= pwdata[15:0];
                        if (!r_have_prev) begin
                            r_fsc <= pwdata[15:0];
                        end
                    end
                    REG_ADAPTIVE_GAIN: r_adaptive_gain <= pwdata[15:0];
                    REG_SOURCE_WIDTH:  r_source_width <= pwdata[13:0];
                    REG_SOURCE_HEIGHT: r_source_height <= pwdata[13:0];
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_red       <= i_red;
                        r_green     <= i_green;
                        r_blue      <= i_blue;
                        r_time      <= i_frame_time;
                        r_frame_end <= i_frame_end;
                        r_gx        <= r_grid_col;
                        r_ncols     <= '0;
                        r_nrows     <= '0;
                        r_hsv_ok    <= 1'b0;
                        r_state     <= S_COL;
                    end
                end
                S_COL: begin
                    if (!row_in) begin
                        r_state <= S_DONE;
                    end else if (col_hit) begin
                        r_gx    <= r_gx + GXW'(1);
                        r_ncols <= r_ncols + GXW'(1);
                    end else begin
                        r_gy    <= r_grid_row;
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (!row_hit) begin
                        r_state <= S_DONE;
                    end else if (r_ncols == '0) begin
                        r_gy    <= r_gy + GYW'(1);
                        r_nrows <= r_nrows + GYW'(1);
                    end else if (!r_hsv_ok) begin
                        r_state <= S_HSV;
                    end else begin
                        r_cx    <= r_grid_col;
                        r_state <= S_RD;
                    end
                end
                S_HSV: begin
                    r_val <= {mx, 8'd0};
                    if (d == 8'd0) begin
                        r_hue    <= '0;
                        r_sat    <= '0;
                        r_hsv_ok <= 1'b1;
                        r_cx     <= r_grid_col;
                        r_state  <= S_RD;
                    end else begin
                        r_state <= S_HSV_WAIT;
                    end
                end
                S_HSV_WAIT: begin
                    if (div_a_done && div_b_done) begin
                        r_hue    <= div_a_quot[15:0];
                        r_sat    <= div_b_quot[15:0];
                        r_hsv_ok <= 1'b1;
                        r_cx     <= r_grid_col;
                        r_state  <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_s      <= s_sum;
                    r_cmp_ok <= ram_rdata[48];
                    r_state  <= S_ACC;
                end
                S_ACC: begin
                    if (r_cmp_ok) begin
                        r_sum      <= r_sum + SUMW'(q3);
                        r_compared <= r_compared + CMPW'(1);
                    end
                    r_cx <= cx_next;
                    if (cx_next == r_gx) begin
                        r_gy    <= r_gy + GYW'(1);
                        r_nrows <= r_nrows + GYW'(1);
                        r_state <= S_ROW;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (r_frame_end) begin
                        r_col      <= '0;
                        r_row      <= '0;
                        r_grid_col <= '0;
                        r_grid_row <= '0;
                        r_state    <= S_FDIV;
                    end else begin
                        if (DW1'(r_col) + DW1'(1) >= w_eff) begin
                            r_col      <= '0;
                            r_grid_col <= '0;
                            r_grid_row <= r_grid_row + r_nrows;
                            if (row_in) begin
                                r_row <= r_row + DW1'(1);
                            end
                        end else begin
                            r_col      <= r_col + DIM_BITS'(1);
                            r_grid_col <= r_grid_col + r_ncols;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FDIV: begin
                    if (r_have_prev && (r_compared != '0)) begin
                        r_state <= S_FDIV_WAIT;
                    end else begin
                        r_delta <= '0;
                        r_state <= S_SDIV;
                    end
                end
                S_FDIV_WAIT: begin
                    if (div_a_done) begin
                        r_delta <= (div_a_quot > DIV_W'(U16_MAX)) ? U16_MAX : div_a_quot[15:0];
                        r_state <= S_SDIV;
                    end
                end
                S_SDIV: begin
                    r_state <= S_SDIV_WAIT;
                end
                S_SDIV_WAIT: begin
                    if (div_a_done) begin
                        r_score <= (div_a_quot > DIV_W'(U16_MAX)) ? U16_MAX : div_a_quot[15:0];
                        r_state <= S_FMUL;
                    end
                end
                S_FMUL: begin
                    r_lhs   <= LHSW'({r_delta, 8'd0}) * LHSW'(r_recent_count);
                    r_rhs   <= RHSW'(r_recent_sum) * RHSW'(r_adaptive_gain);
                    r_state <= S_FOUT;
                end
                S_FOUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_obnd   <= bnd;
                        r_oscore <= r_have_prev ? r_score : 16'd0;
                        r_odelta <= r_have_prev ? r_delta : 16'd0;
                        r_otime  <= r_time;
                        r_ofirst <= !r_have_prev;
                        if (r_have_prev) begin
                            r_fsc          <= n_fsc;
                            r_recent_count <= n_recent_count;
                            r_recent_sum   <= n_recent_sum;
                            for (int i = 1; i < RECENT_LEN; i++) begin
                                r_recent[i-1] <= r_recent[i];
                            end
                            r_recent[RECENT_LEN-1] <= r_delta;
                        end
                        r_prev_time <= r_time;
                        r_have_prev <= 1'b1;
                        r_sum       <= '0;
                        r_compared  <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign pready          = 1'b1;
    assign o_ready         = r_state == S_IDLE;
    assign o_valid         = r_ovalid;
    assign o_is_boundary   = r_obnd;
    assign o_cut_score     = r_oscore;
    assign o_frame_delta   = r_odelta;
    assign o_boundary_time = r_otime;
    assign o_first_frame   = r_ofirst;

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_RD))
        else $error("store compare without a preceding read");

    a_compared_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_compared <= CMPW'(CELLS))
        else $error("more compared samples than grid points");

    a_first_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && o_first_frame) |->
        (!o_is_boundary && (o_frame_delta == 16'd0) && (o_cut_score == 16'd0)))
        else $error("first frame reported a delta or a boundary");

    a_recent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recent_count <= CNTW'(RECENT_LEN))
        else $error("recent delta count overflow");

endmodule

### design/vscd_ram.sv
module vscd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2304
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/vscd_div.sv
module vscd_div #(
    parameter int W = 27
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quot
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_den;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_q;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    assign trial = {r_rem, r_q[W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
            r_q   <= {r_q[W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
